FILE: rtl/fan_speed_pid_controller_macros.svh
// ----------------------------------------------------------------------------
// fan speed pid controller - assertion macros
// short forms for the concurrent checks on the block's ports
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_PID_CONTROLLER_MACROS_SVH
`define FAN_SPEED_PID_CONTROLLER_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define FSPC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fspc check failed");

// next-cycle implication, quiet while reset is held
`define FSPC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fspc check failed");

// next-cycle implication that also holds across reset
`define FSPC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("fspc check failed");

`endif

FILE: rtl/fspc_pkg.sv
// ----------------------------------------------------------------------------
// fspc_pkg
// types, constants and register indexes shared by the fan speed pid controller
// ----------------------------------------------------------------------------
package fspc_pkg;

    localparam int DIV_W  = 24;   // dividend and quotient width
    localparam int DSR_W  = 16;   // divisor width
    localparam int OPA_W  = 17;   // signed multiplier operand
    localparam int GAIN_W = 16;
    localparam int PROD_W = 34;
    localparam int ACC_W  = 36;
    localparam int RPM_W  = 15;
    localparam int DUTY_W = 8;
    localparam int ESUM_W = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    localparam logic [DIV_W-1:0] RPM_NUMERATOR = 24'd15000000;
    localparam logic [RPM_W-1:0] RPM_MAX       = 15'd32767;
    // 8/5 as a reciprocal scaled by 2^15
    localparam logic [GAIN_W-1:0] GROW_RECIP   = 16'd52429;

    localparam logic [GAIN_W-1:0] GAIN_P_RST    = 16'd655;
    localparam logic [GAIN_W-1:0] GAIN_I_RST    = 16'd1311;
    localparam logic [GAIN_W-1:0] GAIN_D_RST    = 16'd20589;
    localparam logic [14:0]       INT_FLOOR_RST = 15'd350;
    localparam logic [14:0]       INT_CEIL_RST  = 15'd20000;
    localparam logic [7:0]        DUTY_FLOOR_RST = 8'd7;
    localparam logic [7:0]        DUTY_CEIL_RST  = 8'd255;
    localparam logic [15:0]       WIN_SPLIT_RST = 16'd1875;
    localparam logic [RPM_W-1:0]  SETPOINT_RST  = 15'd1500;

    localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [IDX_W-1:0] REG_INT_FLOOR  = 3'd3;
    localparam logic [IDX_W-1:0] REG_INT_CEIL   = 3'd4;
    localparam logic [IDX_W-1:0] REG_DUTY_FLOOR = 3'd5;
    localparam logic [IDX_W-1:0] REG_DUTY_CEIL  = 3'd6;
    localparam logic [IDX_W-1:0] REG_WIN_SPLIT  = 3'd7;

    localparam logic CMD_EDGE   = 1'b0;
    localparam logic CMD_TARGET = 1'b1;
    localparam logic KIND_SPEED = 1'b0;
    localparam logic KIND_ECHO  = 1'b1;

    localparam logic [2:0] MAC_LAST_STEP  = 3'd4;
    localparam logic [2:0] GROW_LAST_STEP = 3'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_GROW,
        ST_MUL,
        ST_DUTY,
        ST_OUT
    } fspc_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fspc_div_stat_t;

    typedef struct packed {
        logic issue;
        logic first;
        logic negate;
    } fspc_mac_ctl_t;

endpackage

FILE: rtl/fspc_div.sv
// ----------------------------------------------------------------------------
// fspc_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fspc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fspc_pkg::DIV_W-1:0]    dividend,
    input  logic [fspc_pkg::DSR_W-1:0]    divisor,
    output logic [fspc_pkg::DIV_W-1:0]    quotient,
    output fspc_pkg::fspc_div_stat_t      stat
);
    import fspc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic [DIV_W-1:0] dq_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             qbit;

    assign trial = {rem_reg, dq_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign qbit  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // a zero divisor yields all ones, which saturates like a very fast fan
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            dq_reg  <= {dq_reg[DIV_W-2:0], qbit};
            rem_reg <= qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        end
    end

    assign quotient  = dq_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

FILE: rtl/fspc_mac.sv
// ----------------------------------------------------------------------------
// fspc_mac
// shared signed multiplier with a registered product and an accumulator
// ----------------------------------------------------------------------------
module fspc_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fspc_pkg::fspc_mac_ctl_t            ctl,
    input  logic signed [fspc_pkg::OPA_W-1:0]  op_a,
    input  logic [fspc_pkg::GAIN_W-1:0]        op_b,
    output logic signed [fspc_pkg::ACC_W-1:0]  acc
);
    import fspc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    fspc_mac_ctl_t            pctl_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pctl_reg <= '0;
        end else begin
            pctl_reg <= ctl;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * $signed({1'b0, op_b});
        acc_reg  <= acc_next;
    end

    always_comb begin
        prod_ext = ACC_W'(prod_reg);
        base     = pctl_reg.first ? '0 : acc_reg;
        acc_next = acc_reg;
        if (pctl_reg.issue) begin
            acc_next = pctl_reg.negate ? (base - prod_ext) : (base + prod_ext);
        end
    end

    assign acc = acc_reg;

endmodule

FILE: rtl/fan_speed_pid_controller.sv
// ----------------------------------------------------------------------------
// fan_speed_pid_controller
// fan speed pid loop: tach period to rpm, clamped integral with a one-time
// correction on the first target crossing, and a clamped pwm duty
// ----------------------------------------------------------------------------
//  channel  direction  tdata (low bit first)                  tuser
//  s_       in         period_count, window_count, target_rpm command
//  m_       out        rpm, duty                              kind
//  cfg_     in         index and 16-bit data, no read-back    -
//
//  one item at a time; a set-target item goes straight to its echo, a dropped edge back to idle
//  a used edge runs through the divide, sum, multiply and duty states, the serial divider
//  dominating; the first crossing of a falling target adds a grow step for a multiply
//  the single result register lets the next item in while a result waits;
//  m_tready low holds the block in its output state until the slot frees
//  reset is synchronous, active low, and restores the loop state and config registers, not the data registers
// ----------------------------------------------------------------------------
module fan_speed_pid_controller (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [47:0]                   s_tdata,  // period_count, window_count, target_rpm
    input  logic                          s_tuser,  // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,  // rpm, duty
    output logic                          m_tuser,  // kind
    input  logic                          cfg_wr_en,
    input  logic [fspc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [fspc_pkg::CFG_W-1:0]    cfg_wdata
);
    import fspc_pkg::*;

    // configuration
    logic [15:0] gain_p_reg, gain_i_reg, gain_d_reg, win_split_reg;
    logic [14:0] int_floor_reg, int_ceil_reg;
    logic [7:0]  duty_floor_reg, duty_ceil_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
            int_floor_reg  <= INT_FLOOR_RST;
            int_ceil_reg   <= INT_CEIL_RST;
            duty_floor_reg <= DUTY_FLOOR_RST;
            duty_ceil_reg  <= DUTY_CEIL_RST;
            win_split_reg  <= WIN_SPLIT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GAIN_P:     gain_p_reg     <= cfg_wdata;
                REG_GAIN_I:     gain_i_reg     <= cfg_wdata;
                REG_GAIN_D:     gain_d_reg     <= cfg_wdata;
                REG_INT_FLOOR:  int_floor_reg  <= cfg_wdata[14:0];
                REG_INT_CEIL:   int_ceil_reg   <= cfg_wdata[14:0];
                REG_DUTY_FLOOR: duty_floor_reg <= cfg_wdata[7:0];
                REG_DUTY_CEIL:  duty_ceil_reg  <= cfg_wdata[7:0];
                REG_WIN_SPLIT:  win_split_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields
    logic              in_cmd;
    logic [15:0]       in_period;
    logic [15:0]       in_window;
    logic [RPM_W-1:0]  in_target;

    assign in_cmd    = s_tuser;
    assign in_period = s_tdata[15:0];
    assign in_window = s_tdata[31:16];
    assign in_target = s_tdata[46:32];

    // loop state and working registers
    fspc_state_t              state_reg, state_next;
    logic                     second_edge_reg, second_edge_next;
    logic                     window_prev_reg, window_prev_next;
    logic                     overshoot_reg, overshoot_next;
    logic                     up_reg, up_next;
    logic [RPM_W-1:0]         setpoint_reg, setpoint_next;
    logic [ESUM_W-1:0]        esum_reg, esum_next;
    logic [RPM_W-1:0]         last_rpm_reg, last_rpm_next;
    logic [RPM_W-1:0]         rpm_reg, rpm_next;
    logic signed [OPA_W-1:0]  err_reg, err_next;
    logic signed [OPA_W-1:0]  diff_reg, diff_next;
    logic [2:0]               step_reg, step_next;
    logic                     res_kind_reg, res_kind_next;
    logic [RPM_W-1:0]         res_rpm_reg, res_rpm_next;
    logic [DUTY_W-1:0]        res_duty_reg, res_duty_next;
    logic                     m_valid_reg, m_valid_next;
    logic                     m_kind_reg;
    logic [RPM_W-1:0]         m_rpm_reg;
    logic [DUTY_W-1:0]        m_duty_reg;
    logic                     out_load;

    // shared units
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DSR_W-1:0]         div_divisor;
    logic [DIV_W-1:0]         div_q;
    fspc_div_stat_t           div_stat;
    fspc_mac_ctl_t            mac_ctl;
    logic signed [OPA_W-1:0]  mac_a;
    logic [GAIN_W-1:0]        mac_b;
    logic signed [ACC_W-1:0]  mac_acc;

    fspc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .stat     (div_stat)
    );

    fspc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .acc     (mac_acc)
    );

    // combinational helpers
    logic                     phase;
    logic signed [OPA_W-1:0]  err_c;
    logic signed [17:0]       sum_c;
    logic [14:0]              clamped;
    logic                     crossed;
    logic signed [19:0]       pwm_c;
    logic [DUTY_W-1:0]        duty_c;

    always_comb begin
        phase   = (in_window > win_split_reg);
        err_c   = $signed({2'b00, setpoint_reg}) - $signed({2'b00, rpm_reg});
        sum_c   = $signed({2'b00, esum_reg}) + 18'(err_c);
        if (sum_c > $signed({3'b000, int_ceil_reg})) begin
            clamped = int_ceil_reg;
        end else if (sum_c < $signed({3'b000, int_floor_reg})) begin
            clamped = int_floor_reg;
        end else begin
            clamped = sum_c[14:0];
        end
        crossed = up_reg ? (rpm_reg > setpoint_reg) : (rpm_reg < setpoint_reg);

        // truncate toward zero
        pwm_c = mac_acc[ACC_W-1:16];
        if (mac_acc[ACC_W-1] && (mac_acc[15:0] != 16'd0)) begin
            pwm_c = pwm_c + 20'sd1;
        end
        if (pwm_c > $signed({12'd0, duty_ceil_reg})) begin
            duty_c = duty_ceil_reg;
        end else if (pwm_c < $signed({12'd0, duty_floor_reg})) begin
            duty_c = duty_floor_reg;
        end else begin
            duty_c = pwm_c[DUTY_W-1:0];
        end
    end

    always_comb begin
        state_next       = state_reg;
        second_edge_next = second_edge_reg;
        window_prev_next = window_prev_reg;
        overshoot_next   = overshoot_reg;
        up_next          = up_reg;
        setpoint_next    = setpoint_reg;
        esum_next        = esum_reg;
        last_rpm_next    = last_rpm_reg;
        rpm_next         = rpm_reg;
        err_next         = err_reg;
        diff_next        = diff_reg;
        step_next        = step_reg;
        res_kind_next    = res_kind_reg;
        res_rpm_next     = res_rpm_reg;
        res_duty_next    = res_duty_reg;
        s_tready         = 1'b0;
        out_load         = 1'b0;
        div_start        = 1'b0;
        div_dividend     = RPM_NUMERATOR;
        div_divisor      = in_period;
        mac_ctl          = '0;
        mac_a            = err_reg;
        mac_b            = gain_p_reg;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (in_cmd == CMD_TARGET) begin
                        setpoint_next  = in_target;
                        overshoot_next = 1'b0;
                        up_next        = (in_target > last_rpm_reg);
                        res_kind_next  = KIND_ECHO;
                        res_rpm_next   = in_target;
                        res_duty_next  = '0;
                        state_next     = ST_OUT;
                    end else if (!second_edge_reg) begin
                        second_edge_next = 1'b1;
                    end else begin
                        second_edge_next = 1'b0;
                        if (phase != window_prev_reg) begin
                            window_prev_next = phase;
                            div_start        = 1'b1;
                            state_next       = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    rpm_next   = (div_q > DIV_W'(RPM_MAX)) ? RPM_MAX : div_q[RPM_W-1:0];
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                err_next      = err_c;
                diff_next     = $signed({2'b00, rpm_reg}) - $signed({2'b00, last_rpm_reg});
                last_rpm_next = rpm_reg;
                step_next     = '0;
                esum_next     = {1'b0, clamped};
                state_next    = ST_MUL;
                // one-time correction on the first crossing of the target
                if (!overshoot_reg && crossed) begin
                    overshoot_next = 1'b1;
                    if (up_reg) begin
                        esum_next = {2'b00, clamped[14:1]};
                    end else begin
                        state_next = ST_GROW;
                    end
                end
            end
            ST_GROW: begin
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd0) begin
                    mac_ctl = '{issue: 1'b1, first: 1'b1, negate: 1'b0};
                    mac_a   = $signed({1'b0, esum_reg});
                    mac_b   = GROW_RECIP;
                end
                // floor(8x/5) as x * 52429 / 2^15, exact for a 15-bit x
                if (step_reg == GROW_LAST_STEP) begin
                    esum_next  = mac_acc[30:15];
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0: begin
                        mac_ctl = '{issue: 1'b1, first: 1'b1, negate: 1'b0};
                        mac_a   = err_reg;
                        mac_b   = gain_p_reg;
                    end
                    3'd1: begin
                        mac_ctl = '{issue: 1'b1, first: 1'b0, negate: 1'b0};
                        mac_a   = $signed({1'b0, esum_reg});
                        mac_b   = gain_i_reg;
                    end
                    3'd2: begin
                        mac_ctl = '{issue: 1'b1, first: 1'b0, negate: 1'b1};
                        mac_a   = diff_reg;
                        mac_b   = gain_d_reg;
                    end
                    default: ;
                endcase
                // last product passes through the product register, then the accumulator
                if (step_reg == MAC_LAST_STEP) begin
                    state_next = ST_DUTY;
                end
            end
            ST_DUTY: begin
                res_kind_next = KIND_SPEED;
                res_rpm_next  = rpm_reg;
                res_duty_next = duty_c;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = out_load | (m_valid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            second_edge_reg <= 1'b0;
            window_prev_reg <= 1'b1;
            overshoot_reg   <= 1'b0;
            up_reg          <= 1'b1;
            setpoint_reg    <= SETPOINT_RST;
            esum_reg        <= '0;
            last_rpm_reg    <= SETPOINT_RST;
            step_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            second_edge_reg <= second_edge_next;
            window_prev_reg <= window_prev_next;
            overshoot_reg   <= overshoot_next;
            up_reg          <= up_next;
            setpoint_reg    <= setpoint_next;
            esum_reg        <= esum_next;
            last_rpm_reg    <= last_rpm_next;
            step_reg        <= step_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rpm_reg      <= rpm_next;
        err_reg      <= err_next;
        diff_reg     <= diff_next;
        res_kind_reg <= res_kind_next;
        res_rpm_reg  <= res_rpm_next;
        res_duty_reg <= res_duty_next;
        if (out_load) begin
            m_kind_reg <= res_kind_reg;
            m_rpm_reg  <= res_rpm_reg;
            m_duty_reg <= res_duty_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {1'b0, m_duty_reg, m_rpm_reg};

endmodule

FILE: rtl/fspc_checker.sv
// ----------------------------------------------------------------------------
// fspc_checker
// port-level checks on the fan speed pid controller, bound to its top level
// ----------------------------------------------------------------------------
`include "fan_speed_pid_controller_macros.svh"

module fspc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);
    import fspc_pkg::*;

    // a stalled result keeps its value
    `FSPC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a target echo carries no duty
    `FSPC_ASSERT_IMP(a_echo_duty_zero, aclk, aresetn, m_tvalid && (m_tuser == KIND_ECHO), m_tdata[22:15] == 8'd0)

    // a target item is followed by its echo, so the input side closes
    `FSPC_ASSERT_NXT(a_target_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == CMD_TARGET), !s_tready)

    // no result survives reset
    `FSPC_ASSERT_NXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid)

endmodule

bind fan_speed_pid_controller fspc_checker u_fspc_checker (.*);
